// ===== sv/pabs_pkg.sv =====
// Package with the codes, patterns and thresholds of the priority alarm beep sequencer.
`default_nettype none
package pabs_pkg;

  localparam int unsigned TuneWidth = 9;

  typedef logic [TuneWidth-1:0] tune_t;

  localparam tune_t TUNE_FAILSAFE  = 9'b001100000;
  localparam tune_t TUNE_ACCESSORY = 9'b001100000;
  localparam tune_t TUNE_ARMING    = 9'b000001010;
  localparam tune_t TUNE_MODE      = 9'b000000010;
  localparam tune_t TUNE_WARNING   = 9'b100100100;
  localparam tune_t TUNE_NONE      = 9'b000000000;

  // Q1.14 value of one half.
  localparam logic signed [15:0] ACC_THRESHOLD = 16'sd8192;

  typedef enum logic [1:0] {
    ALARM_OFF    = 2'd0,
    ALARM_ALWAYS = 2'd1,
    ALARM_ARMED  = 2'd2
  } alarm_mode_t;

  typedef enum logic [1:0] {
    ARM_DISARMED = 2'd0,
    ARM_ARMING   = 2'd1,
    ARM_ARMED    = 2'd2
  } arm_code_t;

  localparam logic [2:0] LEVEL_WARNING = 3'd2;

  typedef enum logic [2:0] {
    REG_FAILSAFE_ALARM    = 3'd0,
    REG_ACCESSORY_ALARM   = 3'd1,
    REG_ARMING_ALARM      = 3'd2,
    REG_MODE_CHANGE_ALARM = 3'd3,
    REG_BATTERY_ALARM     = 3'd4,
    REG_GPS_ALARM         = 3'd5,
    REG_FAILSAFE_CODE     = 3'd6
  } reg_index_t;

endpackage
`default_nettype wire

// ===== sv/priority_alarm_beep_sequencer.sv =====
// Top level of the priority alarm beep sequencer: tick register, pattern selection, shift output.
//
// One input transaction is one tick: arming state, flight mode, accessory level and
// battery and GPS alarm levels. Every tick gives exactly one output transaction whose
// buzz_on says whether the buzzer sounds during that tick.
// Both channels use valid and stall; a transaction completes at a clock edge where
// valid is high and stall is low. A tick first lands in an input register; the selection
// logic then updates the arming trackers and the pattern shift register and loads the
// result into the output register. Throughput is one tick per cycle while the receiver
// does not stall; the bound is the loop through the arming trackers, the last flight
// mode and the pattern shift register.
// When the receiver stalls, the output register holds its result and the input register
// keeps one more tick; only when both are full is in_stall raised.
// The configuration port writes one alarm register per cycle when cfg_write_en is high;
// the user must use it only while no tick is in flight; the block does not enforce this.
// A synchronous reset clears all alarm registers to zero, empties both registers,
// marks the block as disarmed and never armed, and clears the pattern, so every output
// transaction has buzz_on low until the first pattern has been loaded.
`default_nettype none
module priority_alarm_beep_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         arm_status,
  input  wire logic [3:0]         flight_mode,
  input  wire logic signed [15:0] accessory_level,
  input  wire logic [2:0]         battery_level,
  input  wire logic [2:0]         gps_level,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               buzz_on,
  input  wire logic               cfg_write_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [3:0]         cfg_data
);
  import pabs_pkg::*;

  // Configuration registers.
  logic [1:0] failsafe_alarm_mode;
  logic [1:0] accessory_alarm_mode;
  logic [1:0] arming_alarm_mode;
  logic [1:0] mode_change_alarm_mode;
  logic [1:0] battery_alarm_mode;
  logic [1:0] gps_alarm_mode;
  logic [3:0] failsafe_mode_code;

  // Input register.
  logic               tick_valid;
  logic [1:0]         tick_arm;
  logic [3:0]         tick_mode;
  logic signed [15:0] tick_acc;
  logic [2:0]         tick_bat;
  logic [2:0]         tick_gps;

  // Sequencer state.
  logic  seen_armed;
  logic  seen_disarmed;
  logic  tune_loaded;
  tune_t tune_bits_left;
  logic [3:0] previous_mode;

  logic  seen_armed_next;
  logic  seen_disarmed_mid;
  logic  seen_disarmed_next;
  logic  tune_loaded_next;
  tune_t tune_bits_left_next;
  logic [3:0] previous_mode_next;
  logic  buzz_next;

  logic  advance;
  logic  tick_load;
  tune_t tune;
  logic  mode_hit;
  logic  is_armed;
  logic  is_disarmed;
  tune_t loaded_bits;

  function automatic logic alarm_enabled(input logic [1:0] mode, input logic armed_once);
    return (mode == ALARM_ALWAYS) || ((mode == ALARM_ARMED) && armed_once);
  endfunction

  assign advance   = tick_valid && (!out_valid || !out_stall);
  assign tick_load = !tick_valid || advance;
  assign in_stall  = !tick_load;

  assign is_armed    = (tick_arm == ARM_ARMED);
  assign is_disarmed = (tick_arm == ARM_DISARMED);

  always_comb begin
    seen_armed_next    = seen_armed || (is_armed && seen_disarmed);
    seen_disarmed_mid  = seen_disarmed || (is_disarmed && seen_armed_next);
    seen_disarmed_next = seen_disarmed_mid && !is_armed;

    tune     = TUNE_NONE;
    mode_hit = 1'b0;
    if (alarm_enabled(failsafe_alarm_mode, seen_armed_next)
        && (tick_mode == failsafe_mode_code)) begin
      tune = TUNE_FAILSAFE;
    end else if (alarm_enabled(accessory_alarm_mode, seen_armed_next)
                 && (tick_acc > ACC_THRESHOLD)) begin
      tune = TUNE_ACCESSORY;
    end else if (alarm_enabled(arming_alarm_mode, seen_armed_next)
                 && is_armed && seen_disarmed_mid) begin
      tune = TUNE_ARMING;
    end else if (alarm_enabled(mode_change_alarm_mode, seen_armed_next)
                 && (tick_mode != previous_mode)
                 && (tick_mode != failsafe_mode_code)) begin
      tune     = TUNE_MODE;
      mode_hit = 1'b1;
    end else if (alarm_enabled(battery_alarm_mode, seen_armed_next)
                 && (tick_bat >= LEVEL_WARNING)) begin
      tune = TUNE_WARNING;
    end else if (alarm_enabled(gps_alarm_mode, seen_armed_next)
                 && (tick_gps >= LEVEL_WARNING)) begin
      tune = TUNE_WARNING;
    end

    previous_mode_next = mode_hit ? tick_mode : previous_mode;

    // A new pattern is taken only once the previous one has fully shifted out.
    loaded_bits      = tune_bits_left;
    tune_loaded_next = tune_loaded;
    if ((tune != TUNE_NONE) && (tune_bits_left == TUNE_NONE)) begin
      loaded_bits      = tune;
      tune_loaded_next = 1'b1;
    end

    buzz_next           = 1'b0;
    tune_bits_left_next = loaded_bits;
    if (tune_loaded_next) begin
      buzz_next           = loaded_bits[0];
      tune_bits_left_next = loaded_bits >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failsafe_alarm_mode    <= ALARM_OFF;
      accessory_alarm_mode   <= ALARM_OFF;
      arming_alarm_mode      <= ALARM_OFF;
      mode_change_alarm_mode <= ALARM_OFF;
      battery_alarm_mode     <= ALARM_OFF;
      gps_alarm_mode         <= ALARM_OFF;
      failsafe_mode_code     <= 4'd0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FAILSAFE_ALARM:    failsafe_alarm_mode    <= cfg_data[1:0];
        REG_ACCESSORY_ALARM:   accessory_alarm_mode   <= cfg_data[1:0];
        REG_ARMING_ALARM:      arming_alarm_mode      <= cfg_data[1:0];
        REG_MODE_CHANGE_ALARM: mode_change_alarm_mode <= cfg_data[1:0];
        REG_BATTERY_ALARM:     battery_alarm_mode     <= cfg_data[1:0];
        REG_GPS_ALARM:         gps_alarm_mode         <= cfg_data[1:0];
        REG_FAILSAFE_CODE:     failsafe_mode_code     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick_load) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_load && in_valid) begin
      tick_arm  <= arm_status;
      tick_mode <= flight_mode;
      tick_acc  <= accessory_level;
      tick_bat  <= battery_level;
      tick_gps  <= gps_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_armed     <= 1'b0;
      seen_disarmed  <= 1'b1;
      tune_loaded    <= 1'b0;
      tune_bits_left <= TUNE_NONE;
      previous_mode  <= 4'd0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        seen_armed     <= seen_armed_next;
        seen_disarmed  <= seen_disarmed_next;
        tune_loaded    <= tune_loaded_next;
        tune_bits_left <= tune_bits_left_next;
        previous_mode  <= previous_mode_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      buzz_on <= buzz_next;
    end
  end

endmodule
`default_nettype wire
